### src/dash_header_line_deframer_defines.svh
// Assertion macros shared by the deframer checker.
`ifndef DASH_HEADER_LINE_DEFRAMER_DEFINES_SVH
`define DASH_HEADER_LINE_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define DHLD_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define DHLD_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/dhld_pkg.sv
// Types and constants of the dash-header line deframer.
package dhld_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned KIND_W = 2;

  localparam logic [BYTE_W-1:0] DASH_CHAR    = 8'h2D;
  localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [POS_W-1:0]  HEADER_LEN   = 7'd3;
  localparam logic [POS_W-1:0]  LENGTH_TRIM  = 7'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_BODY = 2'd0,
    KIND_DONE = 2'd1,
    KIND_DROP = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  data_byte;
    logic [POS_W-1:0]   position;
    logic [POS_W-1:0]   frame_length;
  } res_t;

endpackage

### src/dhld_if.sv
// Valid/ready channel interfaces for the deframer input and result streams.
interface dhld_in_if;
  logic                        valid;
  logic                        ready;
  logic [dhld_pkg::BYTE_W-1:0] rx_data;

  modport source (output valid, output rx_data, input ready);
  modport sink   (input valid, input rx_data, output ready);
endinterface

interface dhld_out_if;
  logic                        valid;
  logic                        ready;
  logic [dhld_pkg::KIND_W-1:0] kind;
  logic [dhld_pkg::BYTE_W-1:0] data_byte;
  logic [dhld_pkg::POS_W-1:0]  position;
  logic [dhld_pkg::POS_W-1:0]  frame_length;

  modport source (output valid, output kind, output data_byte, output position,
                  output frame_length, input ready);
  modport sink   (input valid, input kind, input data_byte, input position,
                  input frame_length, output ready);
endinterface

### src/dhld_core.sv
// Per-byte framing decision and the link/header/body state registers.
module dhld_core #(
  parameter int MAX_BYTES = 124
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        acc,
  input  logic [dhld_pkg::BYTE_W-1:0] rx_data,
  output logic                        res_vld,
  output dhld_pkg::res_t              res
);

  localparam logic [dhld_pkg::POS_W-1:0] DROP_AT = dhld_pkg::POS_W'(MAX_BYTES - 1);

  logic                        online_r, online_nxt;
  logic                        hunt_r, hunt_nxt;
  logic                        body_r, body_nxt;
  logic [dhld_pkg::POS_W-1:0]  cnt_r, cnt_nxt;
  logic [dhld_pkg::BYTE_W-1:0] prev_r;

  logic                        is_dash;
  logic                        start;
  logic                        hunt_eff;
  logic [dhld_pkg::POS_W-1:0]  cnt_eff;
  logic [dhld_pkg::POS_W-1:0]  cnt_inc;

  assign is_dash  = (rx_data == dhld_pkg::DASH_CHAR);
  assign online_nxt = online_r | is_dash;
  // A hunt opens on a dash after a non-dash while neither hunting nor in a body
  assign start    = online_nxt && (prev_r != dhld_pkg::DASH_CHAR) && is_dash
                    && !hunt_r && !body_r;
  assign hunt_eff = hunt_r | start;
  assign cnt_eff  = start ? '0 : cnt_r;
  assign cnt_inc  = cnt_eff + 1'b1;

  // Decide next state and the result for the current byte
  always_comb begin
    hunt_nxt         = hunt_eff;
    body_nxt         = body_r;
    cnt_nxt          = cnt_eff;
    res_vld          = 1'b0;
    res.kind         = dhld_pkg::KIND_BODY;
    res.data_byte    = rx_data;
    res.position     = cnt_eff;
    res.frame_length = '0;
    if (!online_nxt) begin
      hunt_nxt = hunt_r;
      cnt_nxt  = cnt_r;
    end else if (hunt_eff) begin
      if (!is_dash) begin
        hunt_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_inc;
        if (cnt_inc == dhld_pkg::HEADER_LEN) begin
          body_nxt = 1'b1;
          hunt_nxt = 1'b0;
        end
      end
    end else if (body_r) begin
      res_vld = 1'b1;
      cnt_nxt = cnt_inc;
      if (cnt_inc >= DROP_AT) begin
        body_nxt = 1'b0;
        cnt_nxt  = '0;
        res.kind = dhld_pkg::KIND_DROP;
      end else if (rx_data == dhld_pkg::NEWLINE_CHAR) begin
        body_nxt         = 1'b0;
        cnt_nxt          = '0;
        res.kind         = dhld_pkg::KIND_DONE;
        res.frame_length = cnt_inc - dhld_pkg::LENGTH_TRIM;
      end
    end
  end

  // Advance state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      online_r <= 1'b0;
      hunt_r   <= 1'b0;
      body_r   <= 1'b0;
      cnt_r    <= '0;
      prev_r   <= '0;
    end else if (acc) begin
      online_r <= online_nxt;
      hunt_r   <= hunt_nxt;
      body_r   <= body_nxt;
      cnt_r    <= cnt_nxt;
      prev_r   <= rx_data;
    end
  end

endmodule

### src/dhld_out_reg.sv
// Result register that decouples the result channel from the input channel.
module dhld_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           res_vld,
  input  dhld_pkg::res_t res,
  output logic           out_valid,
  input  logic           out_ready,
  output dhld_pkg::res_t out_res
);

  logic           vld_r, vld_nxt;
  dhld_pkg::res_t res_r;
  logic           acc;

  assign in_ready = !vld_r || out_ready;
  assign acc      = in_valid && in_ready;

  // Load on accept, drain when the sink takes the transaction
  always_comb begin
    vld_nxt = vld_r;
    if (acc) begin
      vld_nxt = res_vld;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Hold payload unless a new result is loaded
  always_ff @(posedge clk) begin
    if (acc && res_vld) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

### src/dash_header_line_deframer.sv
// Top level of the dash-header line deframer.
//
//   channel   dir   payload                                       handshake
//   in_ch     in    rx_data[7:0]                                  valid/ready
//   out_ch    out   kind[1:0] data_byte[7:0] position[6:0]
//                   frame_length[6:0]                             valid/ready
//
// One byte is accepted per cycle unless a stalled result blocks input; its
// result is registered the cycle after acceptance via a single framing pass.
// Bytes that give no result still advance the framing state.
// Reset (rst_n low, synchronous) clears link, hunt, body, count and last byte.
// A stalled result holds; input is still taken in the cycle the result drains.
module dash_header_line_deframer #(
  parameter int MAX_BYTES = 124
) (
  input logic         clk,
  input logic         rst_n,
  dhld_in_if.sink     in_ch,
  dhld_out_if.source  out_ch
);

  logic           acc;
  logic           res_vld;
  dhld_pkg::res_t res;
  dhld_pkg::res_t out_res;

  assign acc = in_ch.valid && in_ch.ready;

  // Framing decision and state
  dhld_core #(.MAX_BYTES(MAX_BYTES)) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .rx_data (in_ch.rx_data),
    .res_vld (res_vld),
    .res     (res)
  );

  // Result register
  dhld_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .res_vld   (res_vld),
    .res       (res),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.kind         = out_res.kind;
  assign out_ch.data_byte    = out_res.data_byte;
  assign out_ch.position     = out_res.position;
  assign out_ch.frame_length = out_res.frame_length;

endmodule

### src/dhld_checker.sv
// Port-level checker for the deframer and its bind to the top level.
`include "dash_header_line_deframer_defines.svh"

module dhld_port_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [dhld_pkg::KIND_W-1:0] out_kind,
  input logic [dhld_pkg::BYTE_W-1:0] out_data_byte,
  input logic [dhld_pkg::POS_W-1:0]  out_position,
  input logic [dhld_pkg::POS_W-1:0]  out_frame_length
);

  // Stalled result transaction keeps its payload
  `DHLD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_data_byte) && $stable(out_position) && $stable(out_frame_length), "stalled result changed")
  // Length is reported only on frame completion
  `DHLD_ASSERT_SAME(a_len_zero, clk, rst_n, out_valid && (out_kind != dhld_pkg::KIND_DONE), out_frame_length == '0, "frame_length set outside completion")
  // An empty result register never blocks input
  `DHLD_ASSERT_SAME(a_ready_empty, clk, rst_n, !out_valid, in_ready, "input blocked with empty result register")
  // Every result lies past the header
  `DHLD_ASSERT_SAME(a_pos_body, clk, rst_n, out_valid, out_position >= dhld_pkg::HEADER_LEN, "result position inside header")

endmodule

bind dash_header_line_deframer dhld_port_checker u_dhld_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_kind         (out_ch.kind),
  .out_data_byte    (out_ch.data_byte),
  .out_position     (out_ch.position),
  .out_frame_length (out_ch.frame_length)
);
